// ===== rtl/core/page_table_order_free_lists_macros.svh =====
// assertion helpers for the page table block
`ifndef PAGE_TABLE_ORDER_FREE_LISTS_MACROS_SVH
`define PAGE_TABLE_ORDER_FREE_LISTS_MACROS_SVH

// checked only out of reset
`define PTOFL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked also across reset
`define PTOFL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/ptofl_pkg.sv =====
package ptofl_pkg;

  localparam int PAGES      = 4096;
  localparam int PAGE_W     = $clog2(PAGES);
  localparam int LINK_W     = 13;
  localparam int CFG_W      = 13;
  localparam int ORDERS     = 11;
  localparam int ORDER_W    = 4;
  localparam int HEAD_IDX_W = (ORDERS > 1) ? $clog2(ORDERS) : 1;
  localparam int MODE_W     = 3;
  localparam int VALUE_W    = 2;

  localparam logic [1:0]        PERM_NORMAL = 2'd2;
  localparam logic [LINK_W-1:0] LINK_NULL   = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET_PERM     = 3'd0,
    MODE_SET_ALLOC    = 3'd1,
    MODE_QUERY_NORMAL = 3'd2,
    MODE_QUERY_ALLOC  = 3'd3,
    MODE_LIST_ADD     = 3'd4,
    MODE_LIST_REMOVE  = 3'd5,
    MODE_GET_HEAD     = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_LINK2,
    ST_LINK3,
    ST_POST
  } ptofl_state_t;

  typedef struct packed {
    logic [1:0] perm;
    logic       alloc;
  } attr_t;

  typedef struct packed {
    logic [LINK_W-1:0] lnk_next;
    logic [LINK_W-1:0] lnk_prev;
  } link_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [PAGE_W-1:0]  page;
    logic [ORDER_W-1:0] order;
    logic [VALUE_W-1:0] value;
  } req_t;

  // a link names a real page when it is not negative
  function automatic logic link_ok(input logic [LINK_W-1:0] link);
    return !link[LINK_W-1];
  endfunction

endpackage

// ===== rtl/core/ptofl_ifs.sv =====
interface ptofl_req_if;
  logic                           valid;
  logic                           ready;
  logic [ptofl_pkg::MODE_W-1:0]  mode;
  logic [ptofl_pkg::PAGE_W-1:0]  page;
  logic [ptofl_pkg::ORDER_W-1:0] order;
  logic [ptofl_pkg::VALUE_W-1:0] value;

  modport source (output valid, mode, page, order, value, input ready);
  modport sink (input valid, mode, page, order, value, output ready);
endinterface

interface ptofl_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [ptofl_pkg::LINK_W-1:0] answer;
  logic                                ignored;

  modport source (output valid, answer, ignored, input ready);
  modport sink (input valid, answer, ignored, output ready);
endinterface

interface ptofl_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ptofl_pkg::CFG_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/core/page_table_order_free_lists.sv =====
// Page table with per-order free lists. Every request word (set or query a
// page's permission or allocated flag, push a normal page onto the head of
// an order's doubly linked free list, unlink a page, read an order's head)
// gives exactly one result word. Page attributes live in one synchronous
// memory and the next/prev links in a second one whose single write port
// has a write strobe per field; list heads sit in flip-flops. A set reads
// the page's attributes, then modifies and writes them back. A list add
// writes the new entry, then the old head's prev link; a list remove writes
// the predecessor's next link, the successor's prev link, then the page's
// own entry, in steps set by the one write port of the link memory.
// Refused requests skip the link steps. After reset a clearing pass zeroes
// the attribute memory, one page per cycle over all 4096 pages, during
// which no request is taken; the pages_in_use register can be written at
// any time and holds 0 after reset.
// Links of a page that was never pushed read back undefined.
module page_table_order_free_lists (
  input  logic        clk,
  input  logic        rst_n,
  ptofl_req_if.sink   in_ch,
  ptofl_rsp_if.source out_ch,
  ptofl_cfg_if.sink   cfg_ch
);

  import ptofl_pkg::*;

  localparam logic [PAGE_W-1:0] CLR_LAST = PAGE_W'(PAGES - 1);

  // state and control
  ptofl_state_t      state_r, state_nxt;
  logic [PAGE_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [CFG_W-1:0]  pages_in_use_r;
  req_t              req_r;
  logic [LINK_W-1:0] aux_r, aux_nxt;
  logic [LINK_W-1:0] head_r [ORDERS];

  // memories and their read registers
  attr_t             attr_mem [PAGES];
  link_t             link_mem [PAGES];
  attr_t             attr_rd_r;
  link_t             link_rd_r;

  // result staging and output register
  logic [LINK_W-1:0] res_answer_r, res_answer_nxt;
  logic              res_ignored_r, res_ignored_nxt;
  logic              out_valid_r;
  logic [LINK_W-1:0] out_answer_r;
  logic              out_ignored_r;

  // decode of the request held in req_r
  mode_t             mode;
  logic              page_ok;
  logic              order_ok;
  logic              is_normal;
  logic              add_ok;
  logic              rm_ok;
  logic [LINK_W-1:0] head_sel;
  logic [LINK_W-1:0] page_link;

  // handshake and write strobes
  logic              in_ready;
  logic              in_fire;
  logic              post_ok;
  logic              post;
  logic              attr_we;
  logic [PAGE_W-1:0] attr_waddr;
  attr_t             attr_wdata;
  logic              lk_we_next;
  logic              lk_we_prev;
  logic [PAGE_W-1:0] lk_waddr;
  logic [LINK_W-1:0] lk_wnext;
  logic [LINK_W-1:0] lk_wprev;
  logic              head_we;
  logic [LINK_W-1:0] head_wdata;

  assign in_fire = in_ch.valid && in_ready;
  assign post_ok = !out_valid_r || out_ch.ready;
  assign in_ch.ready = in_ready;

  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.answer = out_answer_r;
  assign out_ch.ignored = out_ignored_r;

  // request decode
  always_comb begin
    mode      = mode_t'(req_r.mode);
    page_ok   = {1'b0, req_r.page} < pages_in_use_r;
    order_ok  = {1'b0, req_r.order} < (ORDER_W + 1)'(ORDERS);
    is_normal = attr_rd_r.perm == PERM_NORMAL;
    add_ok    = page_ok && order_ok && is_normal;
    rm_ok     = page_ok && order_ok;
    head_sel  = order_ok ? head_r[req_r.order[HEAD_IDX_W-1:0]] : LINK_NULL;
    page_link = {{(LINK_W - PAGE_W){1'b0}}, req_r.page};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == CLR_LAST) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        priority if (mode == MODE_LIST_ADD && add_ok) state_nxt = ST_LINK2;
        else if (mode == MODE_LIST_REMOVE && rm_ok) state_nxt = ST_LINK2;
        else state_nxt = ST_POST;
      end
      ST_LINK2: begin
        state_nxt = (mode == MODE_LIST_REMOVE) ? ST_LINK3 : ST_POST;
      end
      ST_LINK3: begin
        state_nxt = ST_POST;
      end
      ST_POST: begin
        if (post_ok) state_nxt = in_fire ? ST_EXEC : ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready        = 1'b0;
    post            = 1'b0;
    clr_cnt_nxt     = clr_cnt_r;
    attr_we         = 1'b0;
    attr_waddr      = req_r.page;
    attr_wdata      = attr_rd_r;
    lk_we_next      = 1'b0;
    lk_we_prev      = 1'b0;
    lk_waddr        = req_r.page;
    lk_wnext        = LINK_NULL;
    lk_wprev        = LINK_NULL;
    head_we         = 1'b0;
    head_wdata      = LINK_NULL;
    aux_nxt         = aux_r;
    res_answer_nxt  = res_answer_r;
    res_ignored_nxt = res_ignored_r;
    unique case (state_r)
      ST_CLEAR: begin
        attr_we     = 1'b1;
        attr_waddr  = clr_cnt_r;
        attr_wdata  = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_EXEC: begin
        res_answer_nxt  = '0;
        res_ignored_nxt = 1'b0;
        unique case (mode)
          MODE_SET_PERM: begin
            res_ignored_nxt = !page_ok;
            attr_we         = page_ok;
            attr_wdata.perm = req_r.value;
          end
          MODE_SET_ALLOC: begin
            res_ignored_nxt  = !page_ok;
            attr_we          = page_ok;
            attr_wdata.alloc = req_r.value != '0;
          end
          MODE_QUERY_NORMAL: begin
            res_ignored_nxt = !page_ok;
            res_answer_nxt  = LINK_W'(page_ok && is_normal);
          end
          MODE_QUERY_ALLOC: begin
            res_ignored_nxt = !page_ok;
            res_answer_nxt  = LINK_W'(page_ok && attr_rd_r.alloc);
          end
          MODE_LIST_ADD: begin
            // new head points at the old head, old head links back later
            res_ignored_nxt = !add_ok;
            lk_we_next      = add_ok;
            lk_we_prev      = add_ok;
            lk_wnext        = head_sel;
            lk_wprev        = LINK_NULL;
            head_we         = add_ok;
            head_wdata      = page_link;
            aux_nxt         = head_sel;
          end
          MODE_LIST_REMOVE: begin
            // predecessor's next link, or the head when there is none
            res_ignored_nxt = !rm_ok;
            if (link_rd_r.lnk_prev != LINK_NULL) begin
              lk_we_next = rm_ok && link_ok(link_rd_r.lnk_prev);
              lk_waddr   = link_rd_r.lnk_prev[PAGE_W-1:0];
              lk_wnext   = link_rd_r.lnk_next;
            end else begin
              head_we    = rm_ok;
              head_wdata = link_rd_r.lnk_next;
            end
          end
          MODE_GET_HEAD: begin
            res_ignored_nxt = !order_ok;
            res_answer_nxt  = head_sel;
          end
          default: res_ignored_nxt = 1'b1;
        endcase
      end
      ST_LINK2: begin
        if (mode == MODE_LIST_REMOVE) begin
          // successor links back to the predecessor
          lk_we_prev = link_ok(link_rd_r.lnk_next);
          lk_waddr   = link_rd_r.lnk_next[PAGE_W-1:0];
          lk_wprev   = link_rd_r.lnk_prev;
        end else begin
          // old head links back to the new one
          lk_we_prev = link_ok(aux_r);
          lk_waddr   = aux_r[PAGE_W-1:0];
          lk_wprev   = page_link;
        end
      end
      ST_LINK3: begin
        lk_we_next = 1'b1;
        lk_we_prev = 1'b1;
      end
      ST_POST: begin
        post     = post_ok;
        in_ready = post_ok;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_cnt_r      <= '0;
      pages_in_use_r <= '0;
      out_valid_r    <= 1'b0;
      for (int i = 0; i < ORDERS; i++) head_r[i] <= LINK_NULL;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (cfg_ch.valid) pages_in_use_r <= cfg_ch.data;
      if (post) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      if (head_we) head_r[req_r.order[HEAD_IDX_W-1:0]] <= head_wdata;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r.mode  <= in_ch.mode;
      req_r.page  <= in_ch.page;
      req_r.order <= in_ch.order;
      req_r.value <= in_ch.value;
    end
    aux_r         <= aux_nxt;
    res_answer_r  <= res_answer_nxt;
    res_ignored_r <= res_ignored_nxt;
    if (post) begin
      out_answer_r  <= res_answer_r;
      out_ignored_r <= res_ignored_r;
    end
  end

  // attribute memory: permission and allocated flag per page
  always_ff @(posedge clk) begin
    if (attr_we) attr_mem[attr_waddr] <= attr_wdata;
    if (in_fire) attr_rd_r <= attr_mem[in_ch.page];
  end

  // link memory: one write port with a strobe per field
  always_ff @(posedge clk) begin
    if (lk_we_next) link_mem[lk_waddr].lnk_next <= lk_wnext;
    if (lk_we_prev) link_mem[lk_waddr].lnk_prev <= lk_wprev;
    if (in_fire) link_rd_r <= link_mem[in_ch.page];
  end

`include "page_table_order_free_lists_macros.svh"

  `PTOFL_ASSERT_RST(a_reset_clears, !rst_n |=> state_r == ST_CLEAR, "reset did not start clear")
  `PTOFL_ASSERT(a_no_accept_in_clear, state_r == ST_CLEAR |-> !in_ready, "accept during clear")
  `PTOFL_ASSERT(a_accept_to_exec, in_fire |=> state_r == ST_EXEC, "accepted word not executed")
  `PTOFL_ASSERT(a_link_write_when_busy, (lk_we_next || lk_we_prev) |-> (state_r == ST_EXEC || state_r == ST_LINK2 || state_r == ST_LINK3), "link write outside list work")
  `PTOFL_ASSERT(a_post_fills_output, post |=> out_valid_r, "result lost at post")

endmodule

// ===== verif/page_table_order_free_lists_checker.sv =====
`timescale 1ns / 1ps
module page_table_order_free_lists_checker (
  input  logic clk,
  input  logic rst_n,
  ptofl_req_if req,
  ptofl_rsp_if rsp,
  ptofl_cfg_if cfg,
  output int   mismatches,
  output int   outstanding
);

  import ptofl_pkg::*;

  typedef struct packed {
    logic signed [LINK_W-1:0] answer;
    logic                     ignored;
  } outcome_t;

  // shadow copy of the page table and list heads
  logic [1:0]        perm_tbl [PAGES];
  logic              alloc_tbl [PAGES];
  logic [LINK_W-1:0] next_tbl [PAGES];
  logic [LINK_W-1:0] prev_tbl [PAGES];
  logic [LINK_W-1:0] head_tbl [ORDERS];
  logic [CFG_W-1:0]  managed;

  outcome_t expected_q[$];
  outcome_t want;
  int       bad;

  function automatic outcome_t serve_request(input logic [MODE_W-1:0]  m,
                                             input logic [PAGE_W-1:0]  pg,
                                             input logic [ORDER_W-1:0] ord,
                                             input logic [VALUE_W-1:0] val);
    outcome_t          res;
    logic              page_in;
    logic              order_in;
    logic [LINK_W-1:0] nxt;
    logic [LINK_W-1:0] prv;
    logic [LINK_W-1:0] old_head;
    res.answer = '0;
    res.ignored = 1'b0;
    page_in = {1'b0, pg} < managed;
    order_in = ord < ORDERS;
    case (m)
      MODE_SET_PERM: begin
        if (page_in) perm_tbl[pg] = val;
        else res.ignored = 1'b1;
      end
      MODE_SET_ALLOC: begin
        if (page_in) alloc_tbl[pg] = (val != '0);
        else res.ignored = 1'b1;
      end
      MODE_QUERY_NORMAL: begin
        if (page_in) res.answer = (perm_tbl[pg] == PERM_NORMAL) ? 13'sd1 : 13'sd0;
        else res.ignored = 1'b1;
      end
      MODE_QUERY_ALLOC: begin
        if (page_in) res.answer = alloc_tbl[pg] ? 13'sd1 : 13'sd0;
        else res.ignored = 1'b1;
      end
      MODE_LIST_ADD: begin
        if (!page_in || !order_in || perm_tbl[pg] != PERM_NORMAL) begin
          res.ignored = 1'b1;
        end else begin
          old_head = head_tbl[ord];
          next_tbl[pg] = old_head;
          prev_tbl[pg] = LINK_NULL;
          if (!old_head[LINK_W-1]) prev_tbl[old_head[PAGE_W-1:0]] = {1'b0, pg};
          head_tbl[ord] = {1'b0, pg};
        end
      end
      MODE_LIST_REMOVE: begin
        if (!page_in || !order_in) begin
          res.ignored = 1'b1;
        end else begin
          nxt = next_tbl[pg];
          prv = prev_tbl[pg];
          // a null prev link makes the given order's head follow the page
          if (prv != LINK_NULL) begin
            if (!prv[LINK_W-1]) next_tbl[prv[PAGE_W-1:0]] = nxt;
          end else begin
            head_tbl[ord] = nxt;
          end
          if (nxt != LINK_NULL && !nxt[LINK_W-1]) prev_tbl[nxt[PAGE_W-1:0]] = prv;
          next_tbl[pg] = LINK_NULL;
          prev_tbl[pg] = LINK_NULL;
        end
      end
      MODE_GET_HEAD: begin
        if (order_in) begin
          res.answer = head_tbl[ord];
        end else begin
          res.answer = LINK_NULL;
          res.ignored = 1'b1;
        end
      end
      default: res.ignored = 1'b1;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (perm_tbl[i]) begin
        perm_tbl[i] = '0;
        alloc_tbl[i] = 1'b0;
        next_tbl[i] = '0;
        prev_tbl[i] = '0;
      end
      foreach (head_tbl[i]) head_tbl[i] = LINK_NULL;
      managed = '0;
      expected_q.delete();
      mismatches <= 0;
      outstanding <= 0;
    end else begin
      bad = 0;
      if (cfg.valid && cfg.ready) managed = cfg.data;
      if (req.valid && req.ready)
        expected_q.push_back(serve_request(req.mode, req.page, req.order, req.value));
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result word, answer %0d ignored %0b",
                   $time, rsp.answer, rsp.ignored);
          bad++;
        end else begin
          want = expected_q.pop_front();
          if (rsp.answer !== want.answer) begin
            $display("%0t: answer mismatch, expected %0d got %0d",
                     $time, want.answer, rsp.answer);
            bad++;
          end
          if (rsp.ignored !== want.ignored) begin
            $display("%0t: ignored mismatch, expected %0b got %0b",
                     $time, want.ignored, rsp.ignored);
            bad++;
          end
        end
      end
      if (bad != 0) mismatches <= mismatches + bad;
      outstanding <= expected_q.size();
    end
  end

endmodule

// ===== verif/page_table_order_free_lists_tb.sv =====
`timescale 1ns / 1ps
module page_table_order_free_lists_tb;
  import ptofl_pkg::*;

  // generous cap: clearing pass plus every word waiting out long gaps on both sides
  localparam int RUN_LIMIT = 600000;
  localparam int HOT_PAGES = 24;
  localparam int PHASES    = 8;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic rsp_ready = 1'b0;
  logic steady = 1'b0;   // no new gaps and no new stalls begin while set
  int   stall_left = 0;
  int   cycles = 0;
  int   mismatches;
  int   outstanding;

  // what the sender knows, just enough to keep requests legal
  bit [1:0]          perm_seen [PAGES];
  bit                linked [PAGES];   // links written at least once
  logic [CFG_W-1:0]  page_limit = '0;
  logic [PAGE_W-1:0] hot [HOT_PAGES];
  int                effective;

  int unsigned phase_limit [PHASES] = '{64, 4096, 1, 4095, 300, 0, 12, 4096};
  int          phase_quota [PHASES] = '{150, 150, 40, 150, 120, 20, 120, 150};

  ptofl_req_if in_if ();
  ptofl_rsp_if out_if ();
  ptofl_cfg_if cfg_if ();

  assign out_if.ready = rsp_ready;

  page_table_order_free_lists dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  page_table_order_free_lists_checker list_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (in_if),
    .rsp         (out_if),
    .cfg         (cfg_if),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #2 clk = ~clk;

  // hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("page_table_order_free_lists_tb: FAIL");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      rsp_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      rsp_ready <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // one request word; called at a falling edge, returns at one
  task automatic put_word(input logic [MODE_W-1:0]  m,
                          input logic [PAGE_W-1:0]  pg,
                          input logic [ORDER_W-1:0] ord,
                          input logic [VALUE_W-1:0] val);
    logic ok;
    int   g;
    in_if.mode <= m;
    in_if.page <= pg;
    in_if.order <= ord;
    in_if.value <= val;
    in_if.valid <= 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
    ok = {1'b0, pg} < page_limit;
    // every word sent counts toward the phase quota
    effective++;
    if (m == MODE_SET_PERM && ok) perm_seen[pg] = val;
    if (m == MODE_LIST_ADD && ok && ord < ORDERS && perm_seen[pg] == PERM_NORMAL)
      linked[pg] = 1'b1;
    if (!steady) begin
      g = pick_gap();
      if (g > 0) begin
        in_if.valid <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
  endtask

  // drop valid and hold off until every result word is back
  task automatic drain();
    in_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // reprogram the page count while idle, then pick a new set of busy pages
  task automatic write_limit(input logic [CFG_W-1:0] n);
    int base;
    drain();
    repeat (8) @(negedge clk);
    cfg_if.data <= n;
    cfg_if.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    page_limit = n;
    base = (n > HOT_PAGES) ? $urandom_range(0, n - HOT_PAGES) : 0;
    foreach (hot[i]) hot[i] = PAGE_W'(base + i);
    if (n != 0) hot[0] = PAGE_W'(n - 1);
  endtask

  // random word, biased toward lists that actually grow and shrink
  task automatic random_word();
    int                 r;
    int                 start;
    int                 k;
    logic               found;
    logic [MODE_W-1:0]  m;
    logic [PAGE_W-1:0]  pg;
    logic [ORDER_W-1:0] ord;
    logic [VALUE_W-1:0] val;
    r = $urandom_range(0, 99);
    if (r < 14)      m = MODE_SET_PERM;
    else if (r < 22) m = MODE_SET_ALLOC;
    else if (r < 30) m = MODE_QUERY_NORMAL;
    else if (r < 38) m = MODE_QUERY_ALLOC;
    else if (r < 60) m = MODE_LIST_ADD;
    else if (r < 80) m = MODE_LIST_REMOVE;
    else if (r < 96) m = MODE_GET_HEAD;
    else             m = MODE_UNUSED;
    r = $urandom_range(0, 99);
    if (r < 75)      pg = hot[$urandom_range(0, HOT_PAGES - 1)];
    else if (r < 90) pg = PAGE_W'($urandom_range(0, PAGES - 1));
    else             pg = PAGE_W'(page_limit + $urandom_range(0, 2) - 1);   // around the boundary
    ord = ($urandom_range(0, 99) < 85) ? ORDER_W'($urandom_range(0, 3))
                                       : ORDER_W'($urandom_range(0, 15));
    val = VALUE_W'($urandom_range(0, 3));
    if (m == MODE_SET_PERM && $urandom_range(0, 9) < 6) val = PERM_NORMAL;
    // make most pushes land by marking the page normal first
    if (m == MODE_LIST_ADD && {1'b0, pg} < page_limit && perm_seen[pg] != PERM_NORMAL
        && $urandom_range(0, 3) != 0)
      put_word(MODE_SET_PERM, pg, ord, PERM_NORMAL);
    // an unlink must only touch pages whose links were written
    if (m == MODE_LIST_REMOVE && {1'b0, pg} < page_limit && ord < ORDERS && !linked[pg]) begin
      found = 1'b0;
      start = $urandom_range(0, HOT_PAGES - 1);
      for (k = 0; k < HOT_PAGES; k++) begin
        if (!found && linked[hot[(start + k) % HOT_PAGES]]
            && {1'b0, hot[(start + k) % HOT_PAGES]} < page_limit) begin
          pg = hot[(start + k) % HOT_PAGES];
          found = 1'b1;
        end
      end
      if (!found) m = MODE_GET_HEAD;
    end
    put_word(m, pg, ord, val);
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.mode = '0;
    in_if.page = '0;
    in_if.order = '0;
    in_if.value = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    effective = 0;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // nothing managed: page requests are flagged, heads still readable
    write_limit(13'd0);
    put_word(MODE_SET_PERM, 0, 0, PERM_NORMAL);
    put_word(MODE_QUERY_NORMAL, 0, 0, 0);
    put_word(MODE_GET_HEAD, 0, 0, 0);
    put_word(MODE_GET_HEAD, 0, 15, 0);

    // full table: field extremes, every mode, refused pushes, foreign-order unlink
    write_limit(13'd4096);
    put_word(MODE_SET_PERM, 4095, 0, PERM_NORMAL);
    put_word(MODE_QUERY_NORMAL, 4095, 15, 0);    // queries ignore the order
    put_word(MODE_SET_ALLOC, 4095, 0, 3);
    put_word(MODE_QUERY_ALLOC, 4095, 0, 0);
    put_word(MODE_SET_ALLOC, 4095, 0, 0);
    put_word(MODE_QUERY_ALLOC, 4095, 0, 0);
    put_word(MODE_SET_PERM, 0, 0, PERM_NORMAL);
    put_word(MODE_LIST_ADD, 0, 10, 0);
    put_word(MODE_LIST_ADD, 4095, 10, 0);
    put_word(MODE_GET_HEAD, 0, 10, 0);
    put_word(MODE_LIST_ADD, 0, 11, 0);           // order out of range
    put_word(MODE_SET_PERM, 5, 0, 1);
    put_word(MODE_LIST_ADD, 5, 0, 0);            // page not normal
    put_word(MODE_LIST_REMOVE, 4095, 2, 0);      // head of another order moves
    put_word(MODE_GET_HEAD, 0, 2, 0);
    put_word(MODE_LIST_REMOVE, 0, 15, 0);
    put_word(MODE_LIST_REMOVE, 0, 10, 0);
    put_word(MODE_GET_HEAD, 0, 10, 0);
    put_word(MODE_UNUSED, 4095, 0, 3);

    // random phases over several page counts
    for (int ph = 0; ph < PHASES; ph++) begin
      write_limit(CFG_W'(phase_limit[ph]));
      steady = ($urandom_range(0, 3) == 0);
      effective = 0;
      while (effective < phase_quota[ph]) begin
        if ($urandom_range(0, 49) == 0) steady = !steady;
        if ($urandom_range(0, 99) == 0) drain();
        random_word();
      end
    end

    drain();
    steady = 1'b0;
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("page_table_order_free_lists_tb: PASS");
    else
      $display("page_table_order_free_lists_tb: FAIL");
    $finish;
  end

endmodule
